// ===== sv/bitmap_frame_allocator_assert.svh =====
// Assertion macros used by the bitmap frame allocator checker
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off while reset is held
`define BFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfa assertion failed");

// next-cycle implication, also checked during reset
`define BFA_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bfa assertion failed");

`endif

// ===== sv/bfa_pkg.sv =====
// Types and constants of the bitmap frame allocator
package bfa_pkg;

    localparam int FRAME_W = 12;
    localparam logic [12:0] FRAME_LIMIT = 13'd4096;
    localparam logic [12:0] FRAME_COUNT_RST = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_FRAME_COUNT = 1'b0;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_MAPPED    = 2'd1;
    localparam logic [1:0] ST_NO_FREE   = 2'd2;
    localparam logic [1:0] ST_FREED     = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame;
        logic               present;
        logic               writable;
        logic               user_access;
    } t_result;

endpackage

// ===== sv/bfa_bitmap_mem.sv =====
// Bitmap word memory: one write port, one registered read port
module bfa_bitmap_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bitmap_frame_allocator.sv =====
// First-fit page frame allocator over a used/free bitmap memory
//
// Input stream: s_axis_tuser selects allocate (0) or free (1); s_axis_tdata
// carries the page's current frame and the kernel and writable flags.
// Output stream: one transaction per request, status in m_axis_tuser, the
// frame and the page entry bits in m_axis_tdata.
// Configuration: frame_count at APB address 0, readable back; the user must see
// that it is written only while the block is idle, the block does not enforce it.
// Sequence: a request that needs no bitmap access goes from accept to the done
// state and then to the output register; a free first passes the bitmap write
// state; an allocation scans one bitmap word per cycle (up to MAX_FRAMES/32
// words, at most 128), set by the single read port of the bitmap memory.
// One request is in flight at a time; s_axis_tready is high only when idle,
// so the next request is taken at best in the cycle its result turns valid.
// Reset: the bitmap memory is zeroed by a sweep over all its words, during
// which no request is taken; frame_count returns to 4096.
// Stall: the result register holds while m_axis_tready is low; a finished
// request waits for it before the next request is taken.
module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int MAX_FRAMES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // page_frame[11:0], kernel_page, rw_page, zeros
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // frame[11:0], present, writable, user_access, zero
    output logic [1:0]  m_axis_tuser,  // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WORDS = (MAX_FRAMES + 31) / 32;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = (WW + 6 > 14) ? WW + 6 : 14;
    localparam logic [CW-1:0] MAXF = CW'(MAX_FRAMES);
    localparam logic [12:0] LIM_CAP =
        (MAX_FRAMES < 4096) ? 13'(MAX_FRAMES) : FRAME_LIMIT;
    localparam logic [WW-1:0] LAST_WORD = WW'(WORDS - 1);

    t_state              r_state, n_state;
    logic [WW-1:0]       r_w, n_w;
    logic                r_kern, r_wr;
    logic [FRAME_W-1:0]  r_pf;
    t_result             r_res, n_res;
    t_result             r_out, n_out;
    logic                r_ovalid, n_ovalid;
    logic [12:0]         r_frame_count;

    logic                mem_we, mem_re;
    logic [WW-1:0]       mem_waddr, mem_raddr;
    logic [31:0]         mem_wdata, mem_rdata;

    logic [12:0]         lim;
    logic [4:0]          zb;
    logic [WW:0]         nxt;
    logic [CW-1:0]       f_ext, nxt_base, in_pf_ext, pf_ext;
    logic                in_acc;
    logic [FRAME_W-1:0]  in_pf;
    logic                in_op;

    bfa_bitmap_mem #(
        .DEPTH (WORDS),
        .AW    (WW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAME_COUNT) ? {19'd0, r_frame_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_COUNT) begin
            r_frame_count <= pwdata[12:0];
        end
    end

    assign lim       = (r_frame_count > LIM_CAP) ? LIM_CAP : r_frame_count;
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign in_pf     = s_axis_tdata[11:0];
    assign in_op     = s_axis_tuser;
    assign in_pf_ext = CW'(in_pf);
    assign pf_ext    = CW'(r_pf);
    assign nxt       = {1'b0, r_w} + 1'b1;
    assign nxt_base  = CW'({nxt, 5'd0});
    assign f_ext     = CW'({r_w, zb});

    always_comb begin
        zb = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (!mem_rdata[i]) begin
                zb = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_w      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_w      <= n_w;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
        if (in_acc) begin
            r_pf   <= in_pf;
            r_kern <= s_axis_tdata[12];
            r_wr   <= s_axis_tdata[13];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_w           = r_w;
        n_res         = r_res;
        n_out         = r_out;
        n_ovalid      = r_ovalid && !m_axis_tready;
        mem_we        = 1'b0;
        mem_waddr     = r_w;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        s_axis_tready = (r_state == S_IDLE);

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_w    = r_w + 1'b1;
                if (r_w == LAST_WORD) begin
                    n_w     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    n_w     = '0;
                    if (in_op == OP_ALLOC) begin
                        if (in_pf != '0) begin
                            n_res.status = ST_MAPPED;
                            n_res.frame  = in_pf;
                        end else if (lim == '0) begin
                            n_res.status = ST_NO_FREE;
                        end else begin
                            mem_re  = 1'b1;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (in_pf == '0) begin
                            n_res.status = ST_MAPPED;
                        end else begin
                            n_res.status = ST_FREED;
                            if (in_pf_ext < MAXF) begin
                                mem_re    = 1'b1;
                                mem_raddr = in_pf_ext[WW+4:5];
                                n_state   = S_FREE_WR;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                if (!(&mem_rdata)) begin
                    n_state = S_DONE;
                    if (f_ext >= CW'(lim)) begin
                        n_res.status = ST_NO_FREE;
                    end else begin
                        mem_we            = 1'b1;
                        mem_wdata         = mem_rdata | (32'd1 << zb);
                        n_res.status      = ST_ALLOCATED;
                        n_res.frame       = f_ext[FRAME_W-1:0];
                        n_res.present     = 1'b1;
                        n_res.writable    = r_wr;
                        n_res.user_access = !r_kern;
                    end
                end else if (nxt_base >= CW'(lim)) begin
                    n_res.status = ST_NO_FREE;
                    n_state      = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = nxt[WW-1:0];
                    n_w       = nxt[WW-1:0];
                end
            end
            S_FREE_WR: begin
                mem_we    = 1'b1;
                mem_waddr = pf_ext[WW+4:5];
                mem_wdata = mem_rdata & ~(32'd1 << r_pf[4:0]);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {1'b0, r_out.user_access, r_out.writable, r_out.present, r_out.frame};

endmodule

// ===== sv/bfa_checker.sv =====
// Port-level checks of the bitmap frame allocator, bound to the top level
`include "bitmap_frame_allocator_assert.svh"

module bfa_checker
    import bfa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    `BFA_ASSERT_NEXT(a_busy_after_reset, i_clk, !i_rst_n, !s_axis_tready)
    `BFA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n && s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `BFA_ASSERT_NEXT(a_result_held, i_clk, i_rst_n && m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `BFA_ASSERT_IMPL(a_entry_bits, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != ST_ALLOCATED, m_axis_tdata[14:12] == 3'd0)

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
